// ===== hw/rtl/sme_pkg.sv =====
// ----------------------------------------------------------------------------
// Stack machine execute unit package
// Shared operation codes, status codes and control types.
// ----------------------------------------------------------------------------
package sme_pkg;

    localparam int DataW = 32;

    localparam logic [4:0] MODE_NOP  = 5'd0;
    localparam logic [4:0] MODE_POP  = 5'd1;
    localparam logic [4:0] MODE_PSH0 = 5'd2;
    localparam logic [4:0] MODE_PSH1 = 5'd3;
    localparam logic [4:0] MODE_PSHM = 5'd4;
    localparam logic [4:0] MODE_PSHI = 5'd5;
    localparam logic [4:0] MODE_ADD  = 5'd6;
    localparam logic [4:0] MODE_SUB  = 5'd7;
    localparam logic [4:0] MODE_MUL  = 5'd8;
    localparam logic [4:0] MODE_DIVS = 5'd9;
    localparam logic [4:0] MODE_DIVU = 5'd10;
    localparam logic [4:0] MODE_AND  = 5'd11;
    localparam logic [4:0] MODE_OR   = 5'd12;
    localparam logic [4:0] MODE_XOR  = 5'd13;
    localparam logic [4:0] MODE_SHL  = 5'd14;
    localparam logic [4:0] MODE_SHR  = 5'd15;
    localparam logic [4:0] MODE_SHRS = 5'd16;
    localparam logic [4:0] MODE_EQZ  = 5'd17;
    localparam logic [4:0] MODE_EQ   = 5'd18;
    localparam logic [4:0] MODE_NE   = 5'd19;
    localparam logic [4:0] MODE_LTS  = 5'd20;
    localparam logic [4:0] MODE_LTU  = 5'd21;
    localparam logic [4:0] MODE_BR   = 5'd22;
    localparam logic [4:0] MODE_BEQZ = 5'd23;
    localparam logic [4:0] MODE_BNEZ = 5'd24;

    localparam logic [DataW-1:0] ALL_ONES   = 32'hFFFF_FFFF;
    localparam logic [4:0]       SHIFT_MASK = 5'h1F;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_UNDER   = 3'd1,
        ST_OVER    = 3'd2,
        ST_DIV0    = 3'd3,
        ST_INVALID = 3'd4
    } status_t;

    localparam logic [1:0] EXC_NONE    = 2'd0;
    localparam logic [1:0] EXC_DIV0    = 2'd1;
    localparam logic [1:0] EXC_INVALID = 2'd2;

    typedef struct packed {
        logic start;
        logic is_signed;
    } div_ctl_t;

endpackage

// ===== hw/rtl/sme_mem.sv =====
// ----------------------------------------------------------------------------
// Operand stack memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sme_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [31:0]      wdata,
    input  logic [AW-1:0]    raddr,
    output logic [31:0]      rdata
);
    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== hw/rtl/sme_alu.sv =====
// ----------------------------------------------------------------------------
// Stack machine arithmetic and logic unit
// Combinational arithmetic, logic, shift and compare operations.
// ----------------------------------------------------------------------------
module sme_alu (
    input  logic [4:0]  mode,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] r
);
    import sme_pkg::*;

    logic [4:0]  sh;
    logic [31:0] prod;

    assign sh   = b[4:0] & SHIFT_MASK;
    assign prod = a * b;

    always_comb
    begin
        unique case (mode)
            MODE_ADD:  r = a + b;
            MODE_SUB:  r = a - b;
            MODE_MUL:  r = prod;
            MODE_AND:  r = a & b;
            MODE_OR:   r = a | b;
            MODE_XOR:  r = a ^ b;
            MODE_SHL:  r = a << sh;
            MODE_SHR:  r = a >> sh;
            MODE_SHRS: r = 32'($signed(a) >>> sh);
            MODE_EQZ:  r = {31'd0, b == 32'd0};
            MODE_EQ:   r = {31'd0, a == b};
            MODE_NE:   r = {31'd0, a != b};
            MODE_LTS:  r = {31'd0, $signed(a) < $signed(b)};
            MODE_LTU:  r = {31'd0, a < b};
            default:   r = ALL_ONES & 32'd0;
        endcase
    end
endmodule

// ===== hw/rtl/sme_div.sv =====
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring division on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sme_div (
    input  logic                clk,
    input  logic                rst_n,
    input  sme_pkg::div_ctl_t   ctl,
    input  logic [31:0]         a,
    input  logic [31:0]         b,
    output logic                done,
    output logic [31:0]         q
);
    import sme_pkg::*;

    logic        run_reg;
    logic [4:0]  step_reg;
    logic [31:0] rem_reg;
    logic [31:0] dq_reg;
    logic [31:0] mb_reg;
    logic        neg_reg;
    logic [32:0] shifted;
    logic [32:0] diff;
    logic        qbit;
    logic [31:0] qraw;
    logic        na;
    logic        nb;

    assign na      = ctl.is_signed & a[31];
    assign nb      = ctl.is_signed & b[31];
    assign shifted = {rem_reg, dq_reg[31]};
    assign diff    = shifted - {1'b0, mb_reg};
    assign qbit    = ~diff[32];
    assign qraw    = {dq_reg[30:0], qbit};
    assign done    = run_reg && (step_reg == 5'd0);
    assign q       = neg_reg ? (32'd0 - qraw) : qraw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            step_reg <= 5'd0;
        end
        else if (ctl.start)
        begin
            run_reg  <= 1'b1;
            step_reg <= 5'd31;
        end
        else if (run_reg)
        begin
            run_reg  <= (step_reg != 5'd0);
            step_reg <= step_reg - 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            rem_reg <= 32'd0;
            dq_reg  <= na ? (32'd0 - a) : a;
            mb_reg  <= nb ? (32'd0 - b) : b;
            neg_reg <= na ^ nb;
        end
        else if (run_reg)
        begin
            rem_reg <= qbit ? diff[31:0] : shifted[31:0];
            dq_reg  <= qraw;
        end
    end
endmodule

// ===== hw/rtl/stack_machine_execute_unit_core.sv =====
// ----------------------------------------------------------------------------
// Stack machine execute unit
// Executes one decoded instruction per transaction on an operand stack held
// in a synchronous memory, with the top entry cached in a register.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid/in_stall    mode, operand
//   out      output     out_valid/out_stall  status, top_value, depth_now,
//                                            branch_taken, branch_offset,
//                                            sticky_exception
//
// An instruction passes through acceptance, execution and the load of the
// result register. A division by zero that must reload the new top entry from
// memory also passes through a load state. Divides with a non-zero divisor
// wait in a divide state for the one-bit-per-cycle divider.
// One instruction is in flight at a time; a waiting result does not block
// acceptance of the next instruction once it sits in the output register.
// Reset empties the stack and clears the sticky exception; no clearing pass.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit_core #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [4:0]              mode,
    input  logic [31:0]             operand,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [2:0]              status,
    output logic [31:0]             top_value,
    output logic [6:0]              depth_now,
    output logic                    branch_taken,
    output logic signed [7:0]       branch_offset,
    output logic [1:0]              sticky_exception
);
    import sme_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EX   = 5'b00010,
        S_DIV  = 5'b00100,
        S_LD   = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t       state_reg;
    state_t       state_next;
    logic [CW-1:0] count_reg;
    logic [31:0]  top_reg;
    logic [4:0]   mode_reg;
    logic [31:0]  opnd_reg;
    status_t      status_reg;
    logic         taken_reg;
    logic [1:0]   exc_reg;

    logic         out_valid_reg;
    logic [2:0]   o_status_reg;
    logic [31:0]  o_top_reg;
    logic [6:0]   o_depth_reg;
    logic         o_taken_reg;
    logic [7:0]   o_offs_reg;
    logic [1:0]   o_exc_reg;

    logic         we;
    logic [AW-1:0] waddr;
    logic [31:0]  wdata;
    logic [AW-1:0] raddr;
    logic [31:0]  rdata;
    logic [31:0]  alu_r;
    div_ctl_t     div_ctl;
    logic         div_done;
    logic [31:0]  div_q;

    logic         has1;
    logic         has2;
    logic         has3;
    logic         full;
    logic         is_push;
    logic         is_bin;
    logic         is_div;
    logic         is_invalid;
    logic         b_zero;
    logic [31:0]  push_val;
    logic         out_load;

    assign has1       = count_reg >= CW'(1);
    assign has2       = count_reg >= CW'(2);
    assign has3       = count_reg >= CW'(3);
    assign full       = count_reg >= CW'(STACK_DEPTH);
    assign is_push    = (mode_reg >= MODE_PSH0) && (mode_reg <= MODE_PSHI);
    assign is_bin     = (mode_reg >= MODE_ADD) && (mode_reg <= MODE_LTU)
                        && (mode_reg != MODE_EQZ);
    assign is_div     = (mode_reg == MODE_DIVS) || (mode_reg == MODE_DIVU);
    assign is_invalid = mode_reg > MODE_BNEZ;
    assign b_zero     = top_reg == 32'd0;
    assign out_load   = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        unique case (mode_reg)
            MODE_PSH0: push_val = 32'd0;
            MODE_PSH1: push_val = 32'd1;
            MODE_PSHM: push_val = ALL_ONES;
            default:   push_val = opnd_reg;
        endcase
    end

    sme_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    sme_alu u_alu (
        .mode (mode_reg),
        .a    (rdata),
        .b    (top_reg),
        .r    (alu_r)
    );

    sme_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .a     (rdata),
        .b     (top_reg),
        .done  (div_done),
        .q     (div_q)
    );

    always_comb
    begin
        state_next        = state_reg;
        we                = 1'b0;
        waddr             = AW'(count_reg - CW'(2));
        wdata             = alu_r;
        raddr             = AW'(count_reg - CW'(2));
        div_ctl.start     = 1'b0;
        div_ctl.is_signed = mode_reg == MODE_DIVS;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EX;
                end
            end
            S_EX:
            begin
                state_next = S_OUT;
                priority if (is_push && !full)
                begin
                    we    = 1'b1;
                    waddr = AW'(count_reg);
                    wdata = push_val;
                end
                else if (mode_reg == MODE_EQZ && has1)
                begin
                    we    = 1'b1;
                    waddr = AW'(count_reg - CW'(1));
                end
                else if (is_bin && has2 && is_div && b_zero)
                begin
                    raddr = AW'(count_reg - CW'(3));
                    if (has3)
                    begin
                        state_next = S_LD;
                    end
                end
                else if (is_bin && has2 && is_div)
                begin
                    div_ctl.start = 1'b1;
                    state_next    = S_DIV;
                end
                else if (is_bin && has2)
                begin
                    we = 1'b1;
                end
                else
                begin
                    we = 1'b0;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    we         = 1'b1;
                    wdata      = div_q;
                    state_next = S_OUT;
                end
            end
            S_LD:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            exc_reg       <= EXC_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_EX)
            begin
                priority if (is_invalid)
                begin
                    exc_reg <= EXC_INVALID;
                end
                else if (mode_reg == MODE_POP && has1)
                begin
                    count_reg <= count_reg - CW'(1);
                end
                else if ((mode_reg == MODE_BEQZ || mode_reg == MODE_BNEZ) && has1)
                begin
                    count_reg <= count_reg - CW'(1);
                end
                else if (is_push && !full)
                begin
                    count_reg <= count_reg + CW'(1);
                end
                else if (is_bin && has2 && is_div && b_zero)
                begin
                    count_reg <= count_reg - CW'(2);
                    exc_reg   <= EXC_DIV0;
                end
                else if (is_bin && has2 && !is_div)
                begin
                    count_reg <= count_reg - CW'(1);
                end
                else
                begin
                    count_reg <= count_reg;
                end
            end
            else if (state_reg == S_DIV && div_done)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            mode_reg <= mode;
            opnd_reg <= operand;
        end
        if (state_reg == S_EX)
        begin
            status_reg <= ST_OK;
            taken_reg  <= 1'b0;
            priority if (is_invalid)
            begin
                status_reg <= ST_INVALID;
            end
            else if (mode_reg == MODE_NOP)
            begin
                status_reg <= ST_OK;
            end
            else if (mode_reg == MODE_BR)
            begin
                taken_reg <= 1'b1;
            end
            else if (is_push)
            begin
                if (full)
                begin
                    status_reg <= ST_OVER;
                end
                else
                begin
                    top_reg <= push_val;
                end
            end
            else if (mode_reg == MODE_POP || mode_reg == MODE_BEQZ
                     || mode_reg == MODE_BNEZ)
            begin
                if (!has1)
                begin
                    status_reg <= ST_UNDER;
                end
                else
                begin
                    top_reg   <= rdata;
                    taken_reg <= (mode_reg == MODE_BEQZ) ? b_zero
                               : ((mode_reg == MODE_BNEZ) ? !b_zero : 1'b0);
                end
            end
            else if (mode_reg == MODE_EQZ)
            begin
                if (!has1)
                begin
                    status_reg <= ST_UNDER;
                end
                else
                begin
                    top_reg <= alu_r;
                end
            end
            else if (!has2)
            begin
                status_reg <= ST_UNDER;
            end
            else if (is_div && b_zero)
            begin
                status_reg <= ST_DIV0;
            end
            else if (!is_div)
            begin
                top_reg <= alu_r;
            end
            else
            begin
                status_reg <= ST_OK;
            end
        end
        else if (state_reg == S_DIV && div_done)
        begin
            top_reg <= div_q;
        end
        else if (state_reg == S_LD)
        begin
            top_reg <= rdata;
        end
        if (out_load)
        begin
            o_status_reg <= status_reg;
            o_top_reg    <= has1 ? top_reg : 32'd0;
            o_depth_reg  <= 7'(count_reg);
            o_taken_reg  <= taken_reg;
            o_offs_reg   <= taken_reg ? opnd_reg[7:0] : 8'd0;
            o_exc_reg    <= exc_reg;
        end
    end

    assign in_stall         = state_reg != S_IDLE;
    assign out_valid        = out_valid_reg;
    assign status           = o_status_reg;
    assign top_value        = o_top_reg;
    assign depth_now        = o_depth_reg;
    assign branch_taken     = o_taken_reg;
    assign branch_offset    = $signed(o_offs_reg);
    assign sticky_exception = o_exc_reg;
endmodule

// ===== hw/rtl/sme_checker.sv =====
// ----------------------------------------------------------------------------
// Stack machine execute unit checker
// Port-level properties of the execute unit, attached by bind.
// ----------------------------------------------------------------------------
module sme_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input logic [2:0]        status,
    input logic [1:0]        sticky_exception,
    input logic              branch_taken,
    input logic signed [7:0] branch_offset
);
    import sme_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status))
        else $error("Result changed while stalled.");

    a_div0_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_DIV0) |-> sticky_exception == EXC_DIV0)
        else $error("Division by zero not recorded.");

    a_inv_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_INVALID) |-> sticky_exception == EXC_INVALID)
        else $error("Invalid opcode not recorded.");

    a_offs_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !branch_taken |-> branch_offset == 8'sd0)
        else $error("Offset without a taken branch.");
endmodule

bind stack_machine_execute_unit_core sme_checker u_sme_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .sticky_exception (sticky_exception),
    .branch_taken     (branch_taken),
    .branch_offset    (branch_offset)
);
